/* rtl/command_slot_tracker_core_defines.svh */
// Assertion macros for the command slot tracker checker.
`ifndef COMMAND_SLOT_TRACKER_CORE_DEFINES_SVH
`define COMMAND_SLOT_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("command_slot_tracker_core: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("command_slot_tracker_core: check failed");

`endif

/* rtl/cst_pkg.sv */
// Shared types, constants and functions of the command slot tracker.
`default_nettype none

package cst_pkg;

  localparam int MaxSlots  = 32;
  localparam int SlotW     = $clog2(MaxSlots);
  localparam int CountW    = SlotW + 1;
  localparam int CmdW      = 2;
  localparam int StatusW   = 8;
  localparam int DivSteps  = SlotW;
  localparam int DivCntW   = $clog2(DivSteps);

  // Input tdata: slot, device_issue_mask, device_active_mask, task_status
  localparam int InBits    = SlotW + 2 * MaxSlots + StatusW;
  localparam int InDataW   = ((InBits + 7) / 8) * 8;
  localparam int InIssueLo = SlotW;
  localparam int InActLo   = SlotW + MaxSlots;
  localparam int InStatLo  = SlotW + 2 * MaxSlots;

  // Output tdata: granted_slot, completed_mask, device_error
  localparam int OutBits   = SlotW + MaxSlots + 1;
  localparam int OutDataW  = ((OutBits + 7) / 8) * 8;

  localparam logic [StatusW-1:0] StatErr = 8'h01;
  localparam logic [StatusW-1:0] StatDf  = 8'h20;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_ISSUE = 2'd1,
    CMD_SCAN  = 2'd2
  } cmd_e;

  // Controller to datapath strobes
  typedef struct packed {
    logic latch;     // capture input transfer, arm start-pointer reduction
    logic div_step;  // one restoring step of start mod count
    logic find;      // rotating priority search, register grant
    logic commit;    // update slot state, load output register
  } cst_cmd_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [SlotW-1:0] lowest_set(input logic [MaxSlots-1:0] vec);
    logic [SlotW-1:0] idx;
    idx = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = SlotW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/command_slot_tracker_core.sv */
// Top level of the command slot tracker for one disk port.
//
// Input stream (s_axis): one command per transfer. tuser carries the command
// (allocate, mark issued, completion scan); tdata carries the slot number, the
// device issue and active masks and the ATA status byte.
// Output stream (m_axis): exactly one result transfer per input transfer, in
// order. tuser is grant_ok; tdata holds granted_slot, completed_mask and
// device_error.
// cfg_we_i / cfg_wdata_i load the slot count; write only while idle.
// Sequence: an allocate first reduces the start pointer modulo the slot count,
// one bit per cycle, then does a rotating priority search and then commits.
// Issue, scan and unknown commands go straight from acceptance to commit.
// The result appears in the cycle after commit.
// One command is in flight at a time; the output register lets a new command
// be accepted while the previous result waits. When the receiver stalls with
// a result still held, the next command finishes its work and then waits in
// its commit step, holding off further input.
// Reset clears owned and issued slots and the search pointer, sets the slot
// count to 32 and empties the output register.
`default_nettype none

module command_slot_tracker_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cst_pkg::CountW-1:0]  cfg_wdata_i,    // slot_count
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [4:0] slot, [36:5] device_issue_mask, [68:37] device_active_mask,
  // [76:69] task_status, [79:77] zero
  input  wire logic [cst_pkg::InDataW-1:0] s_axis_tdata,
  input  wire logic [cst_pkg::CmdW-1:0]    s_axis_tuser,   // [1:0] command
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [4:0] granted_slot, [36:5] completed_mask, [37] device_error, [39:38] zero
  output logic [cst_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                             m_axis_tuser    // [0] grant_ok
);
  import cst_pkg::*;

  cst_cmd_t cmd;

  cst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  cst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .out_data_o  (m_axis_tdata),
    .out_ok_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/cst_ctrl.sv */
// Sequencing state machine of the command slot tracker.
`default_nettype none

module cst_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [cst_pkg::CmdW-1:0] in_cmd_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output cst_pkg::cst_cmd_t           cmd_o
);
  import cst_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIND = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cmd_o           = '0;
    out_valid_d     = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          cnt_d       = '0;
          state_d     = (in_cmd_i == CMD_ALLOC) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/cst_dp.sv */
// Datapath of the command slot tracker: slot state, search and output register.
`default_nettype none

module cst_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cst_pkg::CountW-1:0] cfg_wdata_i,
  input  wire logic [cst_pkg::CmdW-1:0]   in_cmd_i,
  input  wire logic [cst_pkg::InDataW-1:0] in_data_i,
  input  wire cst_pkg::cst_cmd_t          cmd_i,
  output logic [cst_pkg::OutDataW-1:0]    out_data_o,
  output logic                            out_ok_o
);
  import cst_pkg::*;

  // Configuration and slot state
  logic [CountW-1:0]   slot_count_q;
  logic [MaxSlots-1:0] owned_q, owned_d;
  logic [MaxSlots-1:0] issued_q, issued_d;
  logic [SlotW-1:0]    start_q, start_d;

  // Captured input transfer
  logic [CmdW-1:0]     cmd_q;
  logic [SlotW-1:0]    slot_q;
  logic [MaxSlots-1:0] dev_issue_q;
  logic [MaxSlots-1:0] dev_active_q;
  logic [StatusW-1:0]  status_q;

  // Start pointer reduction and grant
  logic [SlotW-1:0]    sh_q;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [CountW-1:0]   trial;
  logic [SlotW-1:0]    grant_q;
  logic                ok_q;

  // Output register
  logic [SlotW-1:0]    o_slot_q;
  logic                o_ok_q;
  logic [MaxSlots-1:0] o_comp_q;
  logic                o_err_q;

  logic [CountW-1:0]   n_eff;
  logic [MaxSlots-1:0] range_mask;
  logic [MaxSlots-1:0] below_rem;
  logic [MaxSlots-1:0] free_vec;
  logic [MaxSlots-1:0] upper_vec;
  logic [MaxSlots-1:0] completed;
  logic                scan_err;

  // 0 acts as 1, anything above the slot limit as the limit
  always_comb begin
    if (slot_count_q == '0) begin
      n_eff = CountW'(1);
    end else if (slot_count_q > CountW'(MaxSlots)) begin
      n_eff = CountW'(MaxSlots);
    end else begin
      n_eff = slot_count_q;
    end
  end

  // Restoring reduction of start pointer by the slot count, one bit per step
  assign trial = {rem_q[CountW-2:0], sh_q[SlotW-1]};
  assign rem_d = (trial >= n_eff) ? (trial - n_eff) : trial;

  // Rotating priority search: first free at or above rem, else lowest free
  assign range_mask = (n_eff == CountW'(MaxSlots)) ? '1
                    : ((MaxSlots'(1) << n_eff) - MaxSlots'(1));
  assign below_rem  = (MaxSlots'(1) << rem_q[SlotW-1:0]) - MaxSlots'(1);
  assign free_vec   = ~(owned_q | dev_issue_q | dev_active_q) & range_mask;
  assign upper_vec  = free_vec & ~below_rem;

  assign completed  = owned_q & issued_q & ~dev_issue_q;
  assign scan_err   = (completed != '0) && ((status_q & (StatErr | StatDf)) != '0);

  always_comb begin
    owned_d  = owned_q;
    issued_d = issued_q;
    start_d  = start_q;
    case (cmd_q)
      CMD_ALLOC: begin
        if (ok_q) begin
          owned_d[grant_q] = 1'b1;
          start_d          = grant_q + 1'b1;
        end
      end
      CMD_ISSUE: begin
        issued_d[slot_q] = 1'b1;
      end
      CMD_SCAN: begin
        owned_d  = owned_q & ~completed;
        issued_d = issued_q & ~completed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= CountW'(MaxSlots);
      owned_q      <= '0;
      issued_q     <= '0;
      start_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        owned_q  <= owned_d;
        issued_q <= issued_d;
        start_q  <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q        <= in_cmd_i;
      slot_q       <= in_data_i[SlotW-1:0];
      dev_issue_q  <= in_data_i[InIssueLo +: MaxSlots];
      dev_active_q <= in_data_i[InActLo +: MaxSlots];
      status_q     <= in_data_i[InStatLo +: StatusW];
      sh_q         <= start_q;
      rem_q        <= '0;
    end else if (cmd_i.div_step) begin
      sh_q  <= {sh_q[SlotW-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.find) begin
      ok_q    <= (free_vec != '0);
      grant_q <= (upper_vec != '0) ? lowest_set(upper_vec) : lowest_set(free_vec);
    end
    if (cmd_i.commit) begin
      case (cmd_q)
        CMD_ALLOC: begin
          o_slot_q <= ok_q ? grant_q : '0;
          o_ok_q   <= ok_q;
          o_comp_q <= '0;
          o_err_q  <= 1'b0;
        end
        CMD_SCAN: begin
          o_slot_q <= '0;
          o_ok_q   <= 1'b0;
          o_comp_q <= completed;
          o_err_q  <= scan_err;
        end
        default: begin
          o_slot_q <= '0;
          o_ok_q   <= 1'b0;
          o_comp_q <= '0;
          o_err_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_data_o = OutDataW'({o_err_q, o_comp_q, o_slot_q});
  assign out_ok_o   = o_ok_q;

endmodule

`default_nettype wire

/* rtl/cst_chk.sv */
// Port-level checker of the command slot tracker, bound to the top level.
`default_nettype none
`include "command_slot_tracker_core_defines.svh"

module cst_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_valid_i,
  input wire logic                        s_ready_i,
  input wire logic                        m_valid_i,
  input wire logic                        m_ready_i,
  input wire logic [cst_pkg::OutDataW-1:0] m_data_i,
  input wire logic                        m_ok_i
);
  import cst_pkg::*;

  // Held result must not change while stalled
  `CST_ASSERT_NEXT(a_out_hold, m_valid_i && !m_ready_i, m_valid_i && $stable(m_data_i) && $stable(m_ok_i))

  // One command in flight: input closes right after a transfer
  `CST_ASSERT_NEXT(a_one_inflight, s_valid_i && s_ready_i, !s_ready_i)

  // No grant means slot field reads zero
  `CST_ASSERT_NOW(a_nogrant_zero, m_valid_i && !m_ok_i, m_data_i[SlotW-1:0] == '0)

  // A grant carries no scan results
  `CST_ASSERT_NOW(a_grant_noscan, m_valid_i && m_ok_i, m_data_i[OutBits-1:SlotW] == '0)

  // Device error only with at least one completed slot
  `CST_ASSERT_NOW(a_err_has_comp, m_valid_i && m_data_i[OutBits-1], m_data_i[SlotW +: MaxSlots] != '0)

endmodule

bind command_slot_tracker_core cst_chk u_cst_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_axis_tvalid),
  .s_ready_i (s_axis_tready),
  .m_valid_i (m_axis_tvalid),
  .m_ready_i (m_axis_tready),
  .m_data_i  (m_axis_tdata),
  .m_ok_i    (m_axis_tuser)
);

`default_nettype wire
